/* rtl/hpfl_pkg.sv */
// Shared types and constants for the handle pool free list.
`default_nettype none

package hpfl_pkg;

  // Id width is fixed by the handle field on the ports.
  localparam int unsigned IdW = 10;

  // Marker written into an entry on remove.
  localparam logic [63:0] VoidMarker = 64'h0000_0000_deca_fbad;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

endpackage

`default_nettype wire

/* rtl/hpfl_ram.sv */
// Single write port, single read port synchronous RAM with registered read data.
`default_nettype none

module hpfl_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/handle_pool_free_list_core.sv */
// Top level of the handle pool: id allocator with free stack and value table.
`default_nettype none

// Handle pool with a LIFO free list.
// Command channel: present action_i, value_in_i and id_in_i with start high;
// the word is taken at a rising edge where start is high and busy is low.
// Actions: add binds value_in_i to a fresh id (most recently freed id first,
// else the next never-used id), remove writes the void marker into the entry
// and pushes its id unless the stack is full, lookup returns the stored value.
// Result channel: valid_o is high for exactly one cycle with id_out_o,
// value_out_o and status_o; the receiver must take it then, it cannot stall.
// Timing: the word is taken in idle and the free stack (add) or value table
// (lookup) is read at that edge; the read-modify-write runs in the execute
// state (busy high), where the result word is registered, after which
// valid_o carries it. Busy drops as the result shows, so a new word can be
// taken while the result is shown, but not while the previous one executes.
// Reset clears the free count, the high-water mark and the control state.
// The RAMs themselves are not cleared: every id below the high-water mark was
// written by an add, so no unwritten entry is ever returned.
module handle_pool_free_list_core #(
  parameter int unsigned CAPACITY    = 1024,
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [1:0]             action_i,
  input  wire logic [VALUE_WIDTH-1:0] value_in_i,
  input  wire logic [9:0]             id_in_i,
  output logic                        valid_o,
  output logic [9:0]                  id_out_o,
  output logic [VALUE_WIDTH-1:0]      value_out_o,
  output logic [1:0]                  status_o
);

  import hpfl_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CmpW = (CntW > IdW) ? CntW : IdW;
  localparam logic [CntW-1:0] CapC = CntW'(CAPACITY);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                   state_q, state_d;
  logic [CntW-1:0]        free_count_q, free_count_d;
  logic [CntW-1:0]        high_water_q, high_water_d;
  logic [1:0]             action_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [IdW-1:0]         id_q;
  logic                   valid_q;
  logic                   accept;

  // RAM ports
  logic                   tbl_we;
  logic [IdxW-1:0]        tbl_waddr;
  logic [VALUE_WIDTH-1:0] tbl_wdata;
  logic                   tbl_re;
  logic [VALUE_WIDTH-1:0] tbl_rdata;
  logic                   stk_we;
  logic                   stk_re;
  logic [IdW-1:0]         stk_rdata;
  logic [CntW-1:0]        fc_minus1;

  // Result words
  logic [IdW-1:0]         id_res;
  logic [VALUE_WIDTH-1:0] val_res;
  status_e                st_res;

  // Widened views for compares and indexing
  logic [CmpW-1:0]        id_ext;
  logic [CmpW-1:0]        hw_ext;
  logic [CmpW-1:0]        slot_ext;
  logic                   id_in_range;

  assign busy   = (state_q == S_EXEC);
  assign accept = start && !busy;

  // Read side: issue the stack read (add) or the table read (lookup) as the word is taken.
  assign fc_minus1 = free_count_q - CntW'(1);
  assign stk_re    = accept && (action_i == ACT_ADD);
  assign tbl_re    = accept && (action_i == ACT_LOOKUP);

  assign id_ext      = CmpW'(id_q);
  assign hw_ext      = CmpW'(high_water_q);
  assign slot_ext    = CmpW'(stk_rdata);
  assign id_in_range = id_ext < hw_ext;

  hpfl_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_WIDTH)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (id_in_i[IdxW-1:0]),
    .rdata_o (tbl_rdata)
  );

  hpfl_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (IdW)
  ) u_free_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (free_count_q[IdxW-1:0]),
    .wdata_i (id_q),
    .re_i    (stk_re),
    .raddr_i (fc_minus1[IdxW-1:0]),
    .rdata_o (stk_rdata)
  );

  // Modify and write back in the execute cycle.
  always_comb begin
    free_count_d = free_count_q;
    high_water_d = high_water_q;
    tbl_we       = 1'b0;
    tbl_waddr    = id_ext[IdxW-1:0];
    tbl_wdata    = value_q;
    stk_we       = 1'b0;
    id_res       = id_q;
    val_res      = '0;
    st_res       = ST_OK;
    state_d      = state_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        case (action_q)
          ACT_ADD: begin
            if (free_count_q != '0) begin
              // Pop the most recently freed id.
              free_count_d = fc_minus1;
              tbl_we       = 1'b1;
              tbl_waddr    = slot_ext[IdxW-1:0];
              id_res       = stk_rdata;
            end else if (high_water_q < CapC) begin
              // Take the next never-used id.
              high_water_d = high_water_q + CntW'(1);
              tbl_we       = 1'b1;
              tbl_waddr    = hw_ext[IdxW-1:0];
              id_res       = hw_ext[IdW-1:0];
            end else begin
              id_res = '0;
              st_res = ST_FULL;
            end
          end
          ACT_REMOVE: begin
            if (id_in_range) begin
              tbl_we    = 1'b1;
              tbl_wdata = VoidMarker[VALUE_WIDTH-1:0];
              // Drop the push once the stack is full.
              if (free_count_q < CapC) begin
                stk_we       = 1'b1;
                free_count_d = free_count_q + CntW'(1);
              end
            end else begin
              st_res = ST_RANGE;
            end
          end
          ACT_LOOKUP: begin
            if (id_in_range) begin
              val_res = tbl_rdata;
            end else begin
              st_res = ST_RANGE;
            end
          end
          default: begin
            st_res = ST_OK;
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      free_count_q <= '0;
      high_water_q <= '0;
      valid_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_count_q <= free_count_d;
      high_water_q <= high_water_d;
      valid_q      <= (state_q == S_EXEC);
    end
  end

  // Latch the command word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_i;
      value_q  <= value_in_i;
      id_q     <= id_in_i;
    end
  end

  // Register the result word.
  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      id_out_o    <= id_res;
      value_out_o <= val_res;
      status_o    <= st_res;
    end
  end

  assign valid_o = valid_q;

  a_exec_then_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (valid_o && !busy))
    else $error("execute cycle not followed by a result");

  a_counts_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_count_q <= CapC) && (high_water_q <= CapC))
    else $error("free count or high-water mark beyond capacity");

  a_full_means_exhausted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o == ST_FULL)) |-> ((free_count_q == '0) && (high_water_q == CapC)))
    else $error("pool full reported while ids remain");

  a_hw_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> (high_water_q == $past(high_water_q) && free_count_q == $past(free_count_q)))
    else $error("pool state changed outside the execute cycle");

endmodule

`default_nettype wire
